/* rtl/core/itbp_pkg.sv */
package itbp_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int ID_WIDTH_DEF  = 16;
  localparam int CFG_WIDTH     = 5;
  localparam logic [CFG_WIDTH-1:0] SLOTS_ENABLED_RST = 5'd16;

  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [2:0] STATUS_FOUND    = 3'd0;
  localparam logic [2:0] STATUS_CLAIMED  = 3'd1;
  localparam logic [2:0] STATUS_RELEASED = 3'd2;
  localparam logic [2:0] STATUS_MISS     = 3'd3;
  localparam logic [2:0] STATUS_BAD_ID   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] owner_id;
  } itbp_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
  } itbp_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } itbp_state_t;

endpackage

/* rtl/core/id_tagged_buffer_pool.sv */
// Pool of buffer slots, each free or owned by a nonzero ID. An acquire returns the slot
// the ID already owns or claims the lowest free slot (status "newly claimed"), a lookup
// only finds, a release frees. Every request gives exactly one result beat. A request with
// an ID of zero or an unknown kind finishes without a scan. Any other request walks the
// owner RAM one slot per cycle from slot 0, with a single comparator checking ownership
// and noting the first free slot in the same pass; a scan stops early on a match. The
// input is stalled while a request is in flight, and the result sits in an output register
// so the next request can start while it waits to be taken. The user must write
// slots_enabled only while idle; the block itself does not enforce this. Zero acts as one
// and values above the pool size act as the pool size.
module id_tagged_buffer_pool #(
  parameter int NUM_SLOTS = itbp_pkg::NUM_SLOTS_DEF,
  parameter int ID_WIDTH  = itbp_pkg::ID_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  itbp_pkg::itbp_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output itbp_pkg::itbp_out_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [itbp_pkg::CFG_WIDTH-1:0]      cfg_wr_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = (CNT_W > itbp_pkg::CFG_WIDTH) ? CNT_W : itbp_pkg::CFG_WIDTH;

  itbp_pkg::itbp_state_t state_r, state_nxt;

  logic [itbp_pkg::CFG_WIDTH-1:0] slots_enabled_r;
  logic [NUM_SLOTS-1:0]           in_use_r;
  logic [ID_WIDTH-1:0]            id_r, id_nxt;
  logic [1:0]                     kind_r, kind_nxt;
  logic [IDX_W-1:0]               addr_r, addr_nxt;
  logic                           issue_r, issue_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]               rd_idx_r, rd_idx_nxt;
  logic                           free_found_r, free_found_nxt;
  logic [IDX_W-1:0]               free_idx_r, free_idx_nxt;
  logic [2:0]                     res_status_r, res_status_nxt;
  logic [IDX_W-1:0]               res_idx_r, res_idx_nxt;
  logic                           out_valid_r;
  itbp_pkg::itbp_out_t            out_data_r;

  logic [ID_WIDTH+15:0]  id_ext;
  logic [ID_WIDTH-1:0]   id_in;
  logic [CMP_W-1:0]      cfg_ext;
  logic [IDX_W-1:0]      last_idx;
  logic [ID_WIDTH-1:0]   rd_data;
  logic                  in_accept;
  logic                  out_load;
  logic                  hit;
  logic                  free_now;
  logic                  free_any;
  logic [IDX_W-1:0]      free_sel;
  logic                  scan_done;
  logic                  ram_wr_en;
  logic                  use_wr;
  logic                  use_val;
  logic [IDX_W-1:0]      use_idx;
  logic [IDX_W+3:0]      slot_ext;

  // Owner IDs are taken modulo 2^ID_WIDTH.
  assign id_ext = {{ID_WIDTH{1'b0}}, in_data.owner_id};
  assign id_in  = id_ext[ID_WIDTH-1:0];

  assign cfg_ext = CMP_W'(slots_enabled_r);

  always_comb begin
    if (slots_enabled_r == '0) begin
      last_idx = '0;
    end else if (cfg_ext > CMP_W'(NUM_SLOTS)) begin
      last_idx = IDX_W'(NUM_SLOTS - 1);
    end else begin
      last_idx = IDX_W'(cfg_ext - CMP_W'(1));
    end
  end

  itbp_owner_ram #(
    .DEPTH  (NUM_SLOTS),
    .WIDTH  (ID_WIDTH),
    .ADDR_W (IDX_W)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (free_sel),
    .wr_data (id_r),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != itbp_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == itbp_pkg::S_FINISH) && (!out_valid_r || !out_stall);

  // The compare stage works on the RAM address from the previous cycle.
  assign hit       = rd_vld_r && in_use_r[rd_idx_r] && (rd_data == id_r);
  assign free_now  = rd_vld_r && !in_use_r[rd_idx_r];
  assign free_any  = free_found_r || free_now;
  assign free_sel  = free_found_r ? free_idx_r : rd_idx_r;
  assign scan_done = (state_r == itbp_pkg::S_SCAN) &&
                     (hit || (rd_vld_r && (rd_idx_r == last_idx)));

  always_comb begin
    state_nxt      = state_r;
    id_nxt         = id_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    issue_nxt      = issue_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = addr_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    ram_wr_en      = 1'b0;
    use_wr         = 1'b0;
    use_val        = 1'b0;
    use_idx        = rd_idx_r;

    unique case (state_r)
      itbp_pkg::S_IDLE: begin
        if (in_accept) begin
          id_nxt         = id_in;
          kind_nxt       = in_data.kind;
          addr_nxt       = '0;
          issue_nxt      = 1'b1;
          free_found_nxt = 1'b0;
          res_idx_nxt    = '0;
          res_status_nxt = itbp_pkg::STATUS_MISS;
          state_nxt      = itbp_pkg::S_SCAN;
          unique case (in_data.kind) inside
            itbp_pkg::KIND_ACQUIRE, itbp_pkg::KIND_LOOKUP: begin
              if (id_in == '0) begin
                res_status_nxt = itbp_pkg::STATUS_BAD_ID;
                state_nxt      = itbp_pkg::S_FINISH;
              end
            end
            itbp_pkg::KIND_RELEASE: begin
              if (id_in == '0) begin
                state_nxt = itbp_pkg::S_FINISH;
              end
            end
            default: begin
              state_nxt = itbp_pkg::S_FINISH;
            end
          endcase
        end
      end

      itbp_pkg::S_SCAN: begin
        if (issue_r) begin
          rd_vld_nxt = !scan_done;
          if (addr_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + IDX_W'(1);
          end
        end
        if (free_now && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = rd_idx_r;
        end
        if (scan_done) begin
          issue_nxt      = 1'b0;
          rd_vld_nxt     = 1'b0;
          state_nxt      = itbp_pkg::S_FINISH;
          res_status_nxt = itbp_pkg::STATUS_MISS;
          res_idx_nxt    = '0;
          case (kind_r)
            itbp_pkg::KIND_ACQUIRE: begin
              if (hit) begin
                res_status_nxt = itbp_pkg::STATUS_FOUND;
                res_idx_nxt    = rd_idx_r;
              end else if (free_any) begin
                res_status_nxt = itbp_pkg::STATUS_CLAIMED;
                res_idx_nxt    = free_sel;
                ram_wr_en      = 1'b1;
                use_wr         = 1'b1;
                use_val        = 1'b1;
                use_idx        = free_sel;
              end
            end
            itbp_pkg::KIND_LOOKUP: begin
              if (hit) begin
                res_status_nxt = itbp_pkg::STATUS_FOUND;
                res_idx_nxt    = rd_idx_r;
              end
            end
            itbp_pkg::KIND_RELEASE: begin
              if (hit) begin
                res_status_nxt = itbp_pkg::STATUS_RELEASED;
                res_idx_nxt    = rd_idx_r;
                use_wr         = 1'b1;
                use_val        = 1'b0;
                use_idx        = rd_idx_r;
              end
            end
            default: begin
              res_status_nxt = itbp_pkg::STATUS_MISS;
            end
          endcase
        end
      end

      itbp_pkg::S_FINISH: begin
        if (out_load) begin
          state_nxt = itbp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = itbp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= itbp_pkg::S_IDLE;
      slots_enabled_r <= itbp_pkg::SLOTS_ENABLED_RST;
      in_use_r        <= '0;
      issue_r         <= 1'b0;
      rd_vld_r        <= 1'b0;
      free_found_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      rd_vld_r     <= rd_vld_nxt;
      free_found_r <= free_found_nxt;
      if (cfg_wr_en) begin
        slots_enabled_r <= cfg_wr_data;
      end
      if (use_wr) begin
        in_use_r[use_idx] <= use_val;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign slot_ext = {4'b0000, res_idx_r};

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    kind_r       <= kind_nxt;
    addr_r       <= addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    if (out_load) begin
      out_data_r.status <= res_status_r;
      out_data_r.slot   <= slot_ext[3:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != itbp_pkg::S_IDLE))
    else $error("accepted request did not start the sequencer");

  a_scan_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itbp_pkg::S_SCAN && issue_r) |-> (addr_r <= last_idx))
    else $error("scan address beyond the enabled slots");

  a_claim_marks_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_status_r == itbp_pkg::STATUS_CLAIMED) |=> in_use_r[$past(res_idx_r)])
    else $error("claimed slot not marked in use");

  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_status_r == itbp_pkg::STATUS_RELEASED) |=> !in_use_r[$past(res_idx_r)])
    else $error("released slot still marked in use");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result register overwritten while held");

endmodule

/* rtl/core/itbp_owner_ram.sv */
module itbp_owner_ram #(
  parameter int DEPTH  = itbp_pkg::NUM_SLOTS_DEF,
  parameter int WIDTH  = itbp_pkg::ID_WIDTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* tb/sv/pool_reply_checker.sv */
`timescale 1ns / 1ps

module pool_reply_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  itbp_pkg::itbp_in_t    in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  itbp_pkg::itbp_out_t   out_data,
  input  logic                  cfg_wr_en,
  input  logic [itbp_pkg::CFG_WIDTH-1:0] cfg_wr_data,
  output int                    replies_due,
  output int                    fail_count
);

  localparam int POOL_SIZE = itbp_pkg::NUM_SLOTS_DEF;
  localparam int TAG_W     = itbp_pkg::ID_WIDTH_DEF;
  localparam int CFG_W     = itbp_pkg::CFG_WIDTH;

  logic                    slot_busy [POOL_SIZE];
  logic [TAG_W-1:0]        slot_tag  [POOL_SIZE];
  logic [CFG_W-1:0]        slots_cfg;
  itbp_pkg::itbp_out_t     reply_q [$];
  itbp_pkg::itbp_out_t     want;

  // Mirrors one request against the shadow pool and returns the reply it must produce.
  function automatic itbp_pkg::itbp_out_t predict_pool_reply(input itbp_pkg::itbp_in_t req);
    itbp_pkg::itbp_out_t rsp;
    int        span;
    int        hit;
    int        hole;
    rsp.status = itbp_pkg::STATUS_MISS;
    rsp.slot   = '0;
    span = (slots_cfg == 0) ? 1 : (slots_cfg > POOL_SIZE) ? POOL_SIZE : int'(slots_cfg);
    hit  = -1;
    hole = -1;
    for (int i = 0; i < span; i++) begin
      if (hit < 0 && slot_busy[i] && slot_tag[i] == req.owner_id) hit = i;
      if (hole < 0 && !slot_busy[i]) hole = i;
    end
    case (req.kind) inside
      itbp_pkg::KIND_ACQUIRE, itbp_pkg::KIND_LOOKUP: begin
        if (req.owner_id == '0) begin
          rsp.status = itbp_pkg::STATUS_BAD_ID;
        end else if (hit >= 0) begin
          rsp.status = itbp_pkg::STATUS_FOUND;
          rsp.slot   = hit[3:0];
        end else if (req.kind == itbp_pkg::KIND_ACQUIRE && hole >= 0) begin
          slot_busy[hole] = 1'b1;
          slot_tag[hole]  = req.owner_id;
          rsp.status      = itbp_pkg::STATUS_CLAIMED;
          rsp.slot        = hole[3:0];
        end
      end
      itbp_pkg::KIND_RELEASE: begin
        if (req.owner_id != '0 && hit >= 0) begin
          slot_busy[hit] = 1'b0;
          slot_tag[hit]  = '0;
          rsp.status     = itbp_pkg::STATUS_RELEASED;
          rsp.slot       = hit[3:0];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        slot_busy[i] = 1'b0;
        slot_tag[i]  = '0;
      end
      slots_cfg = itbp_pkg::SLOTS_ENABLED_RST;
      reply_q.delete();
      fail_count = 0;
      replies_due <= 0;
    end else begin
      // A reply can never belong to a request taken on the same edge, so compare first.
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result beat: status %0d slot %0d", out_data.status, out_data.slot);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, out_data.slot);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) reply_q.push_back(predict_pool_reply(in_data));
      if (cfg_wr_en) slots_cfg = cfg_wr_data;
      replies_due <= reply_q.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int         CFG_W       = itbp_pkg::CFG_WIDTH;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         ID_POOL     = 24;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  itbp_pkg::itbp_in_t   in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  itbp_pkg::itbp_out_t  out_data;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;

  int                   replies_due;
  int                   fail_count;
  int                   cycle_count = 0;
  int                   burst_left = 0;
  int                   requests_sent = 0;
  int                   settings_used = 0;
  int                   stall_mode = 0;
  int                   stall_left = 0;
  int                   id_span = 2;
  logic [15:0]          id_set [ID_POOL];

  id_tagged_buffer_pool u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pool_reply_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .replies_due (replies_due),
    .fail_count  (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d replies outstanding", cycle_count,
               replies_due);
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver switches between calm, light, medium and heavy back-pressure stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_request(input logic [1:0] kind, input logic [15:0] id);
    itbp_pkg::itbp_in_t req;
    int       gap;
    req.kind     = kind;
    req.owner_id = id;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // The counter in the checker is registered, so the task samples it only after waiting on the clock.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (replies_due != 0);
  endtask

  task automatic set_slots(input logic [CFG_W-1:0] count);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic random_request();
    int          pick;
    logic [1:0]  kind;
    logic [15:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 42) kind = itbp_pkg::KIND_ACQUIRE;
    else if (pick < 64) kind = itbp_pkg::KIND_LOOKUP;
    else if (pick < 95) kind = itbp_pkg::KIND_RELEASE;
    else kind = KIND_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 4) id = '0;
    else if (pick < 10) id = 16'($urandom_range(0, 16'hFFFF));
    else if (pick < 20) id = id_set[$urandom_range(0, ID_POOL - 1)];
    else id = id_set[$urandom_range(0, id_span - 1)];
    send_request(kind, id);
  endtask

  initial begin
    logic [CFG_W-1:0] setting;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    for (int k = 0; k < ID_POOL; k++) id_set[k] = 16'($urandom_range(1, 16'hFFFF));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pool at full size: zero IDs, the unused kind, claim, reuse of the lowest hole.
    send_request(itbp_pkg::KIND_LOOKUP,  16'h0005);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'h0000);
    send_request(itbp_pkg::KIND_LOOKUP,  16'h0000);
    send_request(itbp_pkg::KIND_RELEASE, 16'h0000);
    send_request(KIND_UNUSED,            16'hFFFF);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'hFFFF);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'hFFFF);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'h0001);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'h8000);
    send_request(itbp_pkg::KIND_RELEASE, 16'hFFFF);
    send_request(itbp_pkg::KIND_LOOKUP,  16'h8000);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'h7FFF);

    // A count of zero behaves as one slot; owned slots above it become invisible.
    set_slots(5'd0);
    send_request(itbp_pkg::KIND_LOOKUP,  16'h8000);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'h1234);
    send_request(itbp_pkg::KIND_LOOKUP,  16'h7FFF);
    send_request(itbp_pkg::KIND_RELEASE, 16'h0001);

    // An oversized count saturates at the pool size and the hidden owners reappear.
    set_slots(5'd31);
    send_request(itbp_pkg::KIND_LOOKUP,  16'h8000);
    send_request(itbp_pkg::KIND_RELEASE, 16'h0001);
    send_request(itbp_pkg::KIND_RELEASE, 16'h0001);

    set_slots(5'd3);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'h00FF);
    send_request(itbp_pkg::KIND_ACQUIRE, 16'h0F00);
    send_request(KIND_UNUSED,            16'h00FF);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: setting = 5'd16;
        1: setting = 5'd1;
        2: setting = 5'd0;
        3: setting = 5'd31;
        4: setting = 5'd2;
        default: setting = CFG_W'($urandom_range(0, 31));
      endcase
      set_slots(setting);
      id_span = $urandom_range(2, ID_POOL);
      // Refresh a few IDs so that later phases also meet owners the pool has never seen.
      for (int k = 0; k < 3; k++) id_set[$urandom_range(0, ID_POOL - 1)] =
        16'($urandom_range(1, 16'hFFFF));
      repeat (143) random_request();
    end

    wait_drained();
    repeat (30) @(posedge clk);
    $display("Sent %0d pool requests across %0d slot-count settings, 0 and 31 among them.",
             requests_sent, settings_used);
    $display("Mismatches or stray beats seen: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/itbp_pkg.sv
rtl/core/itbp_owner_ram.sv
rtl/core/id_tagged_buffer_pool.sv
tb/sv/pool_reply_checker.sv
tb/sv/tb.sv
